// File: rtl/per_source_flood_suppressor_assert.svh
// Assertion macros for the per-source flood suppressor.
// Included by modules that carry concurrent checks; expects clk and rst in scope.
`ifndef PER_SOURCE_FLOOD_SUPPRESSOR_ASSERT_SVH
`define PER_SOURCE_FLOOD_SUPPRESSOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PSFS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PSFS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/psfs_pkg.sv
// Shared types, constants and codes for the per-source flood suppressor.
// No dependencies.
`timescale 1ns / 1ps

package psfs_pkg;

  localparam int NUM_SOURCES = 256;
  localparam int ADDR_W      = $clog2(NUM_SOURCES);
  localparam int SRC_W       = 8;
  localparam int LEVEL_W     = 3;
  localparam int TIME_W      = 32;
  localparam int COUNT_W     = 17;
  localparam int THR_W       = 16;
  localparam int MS_W        = 24;
  localparam int CFG_IDX_W   = 2;
  localparam int VERDICT_W   = 2;
  localparam int ENTRY_W     = COUNT_W + TIME_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic [LEVEL_W-1:0] LEVEL_ERROR   = 3'd3;
  localparam logic [LEVEL_W-1:0] LEVEL_WARNING = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_COUNT_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SUPPRESS_MS     = 2'd2;

  localparam logic [THR_W-1:0] THR_RESET      = 16'd10;
  localparam logic [MS_W-1:0]  WINDOW_RESET   = 24'd1000;
  localparam logic [MS_W-1:0]  SUPPRESS_RESET = 24'd10000;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_PASS  = 2'd0,
    VERDICT_FIRST = 2'd1,
    VERDICT_STILL = 2'd2
  } verdict_t;

  typedef enum logic {
    ST_IDLE,
    ST_CALC
  } state_t;

  typedef struct packed {
    logic [THR_W-1:0] count_threshold;
    logic [MS_W-1:0]  window_len;
    logic [MS_W-1:0]  suppress_len;
  } cfg_t;

  typedef struct packed {
    logic                throttle;
    logic                valid;
    logic [TIME_W-1:0]   window_start;
    logic [COUNT_W-1:0]  event_count;
    logic [TIME_W-1:0]   now_ms;
  } judge_in_t;

  typedef struct packed {
    verdict_t            verdict;
    logic                wr_en;
    logic [TIME_W-1:0]   window_start;
    logic [COUNT_W-1:0]  event_count;
  } judge_out_t;

endpackage

// File: rtl/psfs_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module psfs_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/psfs_judge.sv
// Per-event decision: count update, window check and write-back values.
// Depends on psfs_pkg.
`timescale 1ns / 1ps

module psfs_judge (
  input  psfs_pkg::cfg_t       cfg,
  input  psfs_pkg::judge_in_t  jin,
  output psfs_pkg::judge_out_t jout
);

  logic [psfs_pkg::COUNT_W-1:0] cnt_base;
  logic [psfs_pkg::COUNT_W-1:0] cnt_inc;
  logic [psfs_pkg::COUNT_W-1:0] thr;
  logic [psfs_pkg::TIME_W-1:0]  ws_base;
  logic [psfs_pkg::TIME_W-1:0]  elapsed;
  logic [psfs_pkg::MS_W:0]      hold_limit;

  always_comb begin
    cnt_base   = jin.valid ? jin.event_count : '0;
    ws_base    = jin.valid ? jin.window_start : jin.now_ms;
    cnt_inc    = (cnt_base == psfs_pkg::COUNT_MAX) ? cnt_base
                 : cnt_base + psfs_pkg::COUNT_W'(1);
    elapsed    = jin.now_ms - ws_base;
    thr        = psfs_pkg::COUNT_W'(cfg.count_threshold);
    hold_limit = {1'b0, cfg.window_len} + {1'b0, cfg.suppress_len};

    jout.verdict      = psfs_pkg::VERDICT_PASS;
    jout.wr_en        = jin.throttle;
    jout.window_start = ws_base;
    jout.event_count  = cnt_inc;

    priority if (cnt_inc < thr) begin
      jout.verdict = psfs_pkg::VERDICT_PASS;
    end else if (cnt_inc == thr) begin
      if (elapsed < psfs_pkg::TIME_W'(cfg.window_len)) begin
        jout.verdict = psfs_pkg::VERDICT_FIRST;
      end else begin
        jout.window_start = jin.now_ms;
        jout.event_count  = psfs_pkg::COUNT_W'(1);
      end
    end else begin
      if (elapsed < psfs_pkg::TIME_W'(hold_limit)) begin
        jout.verdict = psfs_pkg::VERDICT_STILL;
      end else begin
        jout.window_start = jin.now_ms;
        jout.event_count  = psfs_pkg::COUNT_W'(1);
      end
    end

    // untracked level or throttling off: pass, leave state alone
    if (!jin.throttle) begin
      jout.verdict = psfs_pkg::VERDICT_PASS;
    end
  end

endmodule

// File: rtl/per_source_flood_suppressor.sv
// Per-source flood suppressor: an event stream in, one verdict per event out.
// The request is taken in the idle state, which issues the state RAM read of
// the source's entry; the verdict is decided and the entry written back in
// the calc state after it, once the output register is free. Each
// read-modify-write ends before the next request is taken; a new request may
// be taken while the previous verdict still waits. Entry valid marks sit in
// flip-flops cleared at once by reset, so the block is ready right after reset.
// Configuration is to be written only while idle; the block does not enforce it.
// Depends on psfs_pkg, psfs_ram, psfs_judge and the assertion header.
`timescale 1ns / 1ps
`include "per_source_flood_suppressor_assert.svh"

module per_source_flood_suppressor (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [39:0]                    s_tdata,   // [7:0] source_id, [39:8] now_ms
  input  logic [2:0]                     s_tuser,   // [2:0] severity
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [7:0]                     m_tdata,   // [1:0] verdict, [7:2] zero
  input  logic                           cfg_we,
  input  logic [psfs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [psfs_pkg::MS_W-1:0]      cfg_data
);

  psfs_pkg::state_t   state;
  psfs_pkg::state_t   state_next;
  psfs_pkg::cfg_t     cfg;
  psfs_pkg::judge_in_t  jin;
  psfs_pkg::judge_out_t jout;

  logic [psfs_pkg::SRC_W-1:0]   src;
  logic [psfs_pkg::LEVEL_W-1:0] level;
  logic [psfs_pkg::TIME_W-1:0]  now_ms;
  logic [psfs_pkg::NUM_SOURCES-1:0] entry_valid;
  logic [psfs_pkg::ADDR_W-1:0]  addr;
  logic [psfs_pkg::ENTRY_W-1:0] rd_entry;
  logic                         accept;
  logic                         advance;
  logic                         mem_we;
  logic                         in_range;
  logic                         level_hit;
  logic [psfs_pkg::VERDICT_W-1:0] verdict;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.count_threshold <= psfs_pkg::THR_RESET;
      cfg.window_len      <= psfs_pkg::WINDOW_RESET;
      cfg.suppress_len    <= psfs_pkg::SUPPRESS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        psfs_pkg::REG_COUNT_THRESHOLD:
          cfg.count_threshold <= cfg_data[psfs_pkg::THR_W-1:0];
        psfs_pkg::REG_WINDOW_MS: cfg.window_len <= cfg_data;
        psfs_pkg::REG_SUPPRESS_MS: cfg.suppress_len <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psfs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    advance    = 1'b0;
    unique case (state)
      psfs_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = psfs_pkg::ST_CALC;
        end
      end
      psfs_pkg::ST_CALC: begin
        if (!m_tvalid || m_tready) begin
          advance    = 1'b1;
          state_next = psfs_pkg::ST_IDLE;
        end
      end
      default: state_next = psfs_pkg::ST_IDLE;
    endcase
  end

  assign accept = s_tvalid && s_tready;

  // capture the request
  always_ff @(posedge clk) begin
    if (accept) begin
      src    <= s_tdata[psfs_pkg::SRC_W-1:0];
      now_ms <= s_tdata[psfs_pkg::SRC_W +: psfs_pkg::TIME_W];
      level  <= s_tuser;
    end
  end

  assign addr = psfs_pkg::ADDR_W'(src);

  psfs_ram #(
    .DATA_W (psfs_pkg::ENTRY_W),
    .DEPTH  (psfs_pkg::NUM_SOURCES)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (addr),
    .wdata ({jout.event_count, jout.window_start}),
    .re    (accept),
    .raddr (psfs_pkg::ADDR_W'(s_tdata[psfs_pkg::SRC_W-1:0])),
    .rdata (rd_entry)
  );

  always_comb begin
    in_range  = 32'(src) < psfs_pkg::NUM_SOURCES;
    level_hit = (level == psfs_pkg::LEVEL_ERROR) || (level == psfs_pkg::LEVEL_WARNING);
    jin.throttle = level_hit && in_range && (cfg.count_threshold != '0)
                   && (cfg.window_len != '0) && (cfg.suppress_len != '0);
    jin.valid        = entry_valid[addr];
    jin.window_start = rd_entry[psfs_pkg::TIME_W-1:0];
    jin.event_count  = rd_entry[psfs_pkg::TIME_W +: psfs_pkg::COUNT_W];
    jin.now_ms       = now_ms;
  end

  psfs_judge u_judge (
    .cfg  (cfg),
    .jin  (jin),
    .jout (jout)
  );

  assign mem_we = advance && jout.wr_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (mem_we) begin
      entry_valid[addr] <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      verdict <= jout.verdict;
    end
  end

  assign m_tdata = {{(8 - psfs_pkg::VERDICT_W){1'b0}}, verdict};

  `PSFS_ASSERT_NXT(a_accept_to_calc, accept, state == psfs_pkg::ST_CALC, "request lost")
  `PSFS_ASSERT_NXT(a_advance_shows_result, advance, m_tvalid, "verdict not presented")
  `PSFS_ASSERT_IMP(a_write_in_calc, mem_we, state == psfs_pkg::ST_CALC, "write outside decision")
  `PSFS_ASSERT_NXT(a_write_sets_valid, mem_we, entry_valid[$past(addr)], "entry not marked valid")

endmodule

// File: tb/testbench.sv
// Self-checking testbench for per_source_flood_suppressor: stream requests in, verdicts out.
// Holds a scoreboard class with its own per-source window state; depends on psfs_pkg and per_source_flood_suppressor.
`timescale 1ns / 1ps

module testbench;
  import psfs_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int MAX_GAP = 12;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  class flood_scoreboard;
    logic [THR_W-1:0]   count_limit;
    logic [MS_W-1:0]    window_len;
    logic [MS_W-1:0]    suppress_len;
    bit                 tracked[NUM_SOURCES];
    logic [TIME_W-1:0]  win_start[NUM_SOURCES];
    logic [COUNT_W-1:0] hits[NUM_SOURCES];
    verdict_t           verdict_q[$];
    int                 failures;
    int                 requests;
    int                 kind_seen[3];

    function new();
      count_limit  = THR_RESET;
      window_len   = WINDOW_RESET;
      suppress_len = SUPPRESS_RESET;
      foreach (tracked[i]) tracked[i] = 1'b0;
      failures = 0;
      requests = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [MS_W-1:0] value);
      case (idx)
        REG_COUNT_THRESHOLD: count_limit = value[THR_W-1:0];
        REG_WINDOW_MS:       window_len = value;
        REG_SUPPRESS_MS:     suppress_len = value;
        default: ;
      endcase
    endfunction

    function verdict_t verdict_for(logic [SRC_W-1:0] src, logic [LEVEL_W-1:0] sev,
                                   logic [TIME_W-1:0] stamp);
      logic [COUNT_W-1:0] cnt;
      logic [TIME_W-1:0]  elapsed;
      verdict_t           v;
      v = VERDICT_PASS;
      if (!(sev == LEVEL_ERROR || sev == LEVEL_WARNING) || count_limit == '0 ||
          window_len == '0 || suppress_len == '0)
        return VERDICT_PASS;
      if (!tracked[src]) begin
        tracked[src] = 1'b1;
        win_start[src] = stamp;
        hits[src] = '0;
      end
      cnt = hits[src];
      if (cnt != COUNT_MAX) cnt = cnt + 1'b1;
      hits[src] = cnt;
      elapsed = stamp - win_start[src];
      if (cnt < count_limit) begin
        v = VERDICT_PASS;
      end else if (cnt == count_limit) begin
        if (elapsed < window_len) begin
          v = VERDICT_FIRST;
        end else begin
          win_start[src] = stamp;
          hits[src] = COUNT_W'(1);
        end
      end else begin
        if (33'(elapsed) < 33'(window_len) + 33'(suppress_len)) begin
          v = VERDICT_STILL;
        end else begin
          win_start[src] = stamp;
          hits[src] = COUNT_W'(1);
        end
      end
      return v;
    endfunction

    function void note_request(logic [SRC_W-1:0] src, logic [LEVEL_W-1:0] sev,
                               logic [TIME_W-1:0] stamp);
      verdict_t v;
      v = verdict_for(src, sev, stamp);
      verdict_q = {verdict_q, v};
      kind_seen[v]++;
      requests++;
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= 10) $display("MISMATCH %0t: %s", $realtime, msg);
    endfunction

    function void check_verdict(logic [7:0] data);
      verdict_t want;
      if (verdict_q.size() == 0) begin
        flag($sformatf("verdict %0d with no request outstanding", data[VERDICT_W-1:0]));
        return;
      end
      want = verdict_q.pop_front();
      if (data[VERDICT_W-1:0] !== want)
        flag($sformatf("verdict expected %0d actual %0d", want, data[VERDICT_W-1:0]));
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [39:0]          s_tdata = '0;
  logic [2:0]           s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [7:0]           m_tdata;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [MS_W-1:0]      cfg_data = '0;

  flood_scoreboard sb = new();
  bit              quiet = 1'b0;
  int              cycle_count = 0;
  int              phases = 0;

  per_source_flood_suppressor u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    int stall;
    forever begin
      stall = quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        m_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready = 1'b1;
      do @(posedge clk); while (rst || m_tvalid !== 1'b1);
      sb.check_verdict(m_tdata);
      @(negedge clk);
    end
  end

  task automatic send_event(input logic [SRC_W-1:0] src, input logic [LEVEL_W-1:0] sev,
                            input logic [TIME_W-1:0] stamp);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = {stamp, src};
    s_tuser = sev;
    do @(posedge clk); while (s_tready !== 1'b1);
    sb.note_request(src, sev, stamp);
    @(negedge clk);
  endtask

  // hold the sender until every outstanding verdict is back
  task automatic settle();
    s_tvalid = 1'b0;
    while (sb.verdict_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MS_W-1:0] value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_reg(idx, value);
  endtask

  task automatic configure(input logic [THR_W-1:0] thr, input logic [MS_W-1:0] win,
                           input logic [MS_W-1:0] sup);
    settle();
    write_reg(REG_COUNT_THRESHOLD, MS_W'(thr));
    write_reg(REG_WINDOW_MS, win);
    write_reg(REG_SUPPRESS_MS, sup);
    phases++;
  endtask

  task automatic run_phase(input logic [THR_W-1:0] thr, input logic [MS_W-1:0] win,
                           input logic [MS_W-1:0] sup, input logic [TIME_W-1:0] base,
                           input int items);
    logic [SRC_W-1:0]  pool[6];
    logic [TIME_W-1:0] now_ms;
    int                step_max;
    int                pick;
    configure(thr, win, sup);
    foreach (pool[i]) pool[i] = SRC_W'($urandom_range(0, NUM_SOURCES - 1));
    now_ms = base;
    step_max = 2 * int'(win) / int'(thr) + 1;
    for (int i = 0; i < items; i++) begin
      if (i % 40 == 0) quiet = ($urandom_range(0, 2) == 0);
      if (i == items / 3) settle();
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        send_event(pool[$urandom_range(0, 5)],
                   $urandom_range(0, 1) ? LEVEL_ERROR : LEVEL_WARNING, now_ms);
      end else begin
        send_event(SRC_W'($urandom_range(0, NUM_SOURCES - 1)),
                   LEVEL_W'($urandom_range(0, 7)), $urandom);
      end
      if ($urandom_range(0, 49) == 0) now_ms = now_ms + win + sup;
      else now_ms = now_ms + $urandom_range(0, step_max);
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int lvl = 0; lvl < 8; lvl++) send_event(8'hFF, LEVEL_W'(lvl), 32'hFFFF_FFFF);

    configure(16'd1, 24'd1, 24'd1);
    send_event(8'h00, LEVEL_WARNING, 32'd0);
    send_event(8'h00, LEVEL_WARNING, 32'd1);
    send_event(8'h00, LEVEL_WARNING, 32'd2);
    send_event(8'h00, LEVEL_ERROR, 32'd2);

    configure(16'd2, 24'd100, 24'd50);
    send_event(8'h01, LEVEL_ERROR, 32'hFFFF_FFF0);
    send_event(8'h01, LEVEL_ERROR, 32'h0000_0010);
    send_event(8'h01, LEVEL_WARNING, 32'h0000_0020);
    send_event(8'h01, LEVEL_ERROR, 32'h0000_0086);
    send_event(8'h02, LEVEL_ERROR, 32'd1000);
    send_event(8'h02, LEVEL_ERROR, 32'd1100);

    configure(16'd0, 24'd100, 24'd50);
    send_event(8'h03, LEVEL_ERROR, 32'd5);
    configure(16'd2, 24'd0, 24'd50);
    send_event(8'h03, LEVEL_ERROR, 32'd5);
    configure(16'd2, 24'd100, 24'd0);
    send_event(8'h03, LEVEL_WARNING, 32'd5);
    configure(16'd2, 24'd100, 24'd50);
    send_event(8'h03, LEVEL_ERROR, 32'd5);
    send_event(8'h03, LEVEL_ERROR, 32'd5);

    configure(16'hFFFF, 24'hFF_FFFF, 24'hFF_FFFF);
    write_reg(REG_UNUSED, 24'hFF_FFFF);
    send_event(8'h04, LEVEL_ERROR, $urandom);

    run_phase(16'd3, 24'd60, 24'd120, $urandom, 265);
    run_phase(16'd5, 24'd200, 24'd300, $urandom, 265);
    run_phase(16'd1, 24'd10, 24'd20, 32'hFFFF_FF00, 265);
    run_phase(16'd8, 24'd500, 24'd1000, $urandom, 265);
    run_phase(THR_W'($urandom_range(1, 12)), MS_W'($urandom_range(1, 400)),
              MS_W'($urandom_range(1, 800)), $urandom, 265);

    settle();
    foreach (sb.verdict_q[i]) sb.flag($sformatf("verdict %0d never arrived", sb.verdict_q[i]));
    $display("covered %0d requests over %0d settings, wrapped stamps and disabled limits included",
             sb.requests, phases);
    $display("verdicts pass/first/still: %0d/%0d/%0d, failures %0d",
             sb.kind_seen[VERDICT_PASS], sb.kind_seen[VERDICT_FIRST],
             sb.kind_seen[VERDICT_STILL], sb.failures);
    if (sb.failures == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/psfs_pkg.sv
rtl/psfs_ram.sv
rtl/psfs_judge.sv
rtl/per_source_flood_suppressor.sv
tb/testbench.sv
